// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the decoder RTL.
// Include guarded; needs clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked on every clock edge outside reset.
`define MSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MSD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/msd_pkg.sv -----
// Shared types, token/error codes, tag values and helper functions
// for the MessagePack stream decoder. No dependencies.
package msd_pkg;

    // token kinds
    localparam logic [3:0] K_NIL   = 4'd0;
    localparam logic [3:0] K_FALSE = 4'd1;
    localparam logic [3:0] K_TRUE  = 4'd2;
    localparam logic [3:0] K_INT   = 4'd3;
    localparam logic [3:0] K_F64   = 4'd4;
    localparam logic [3:0] K_STR   = 4'd5;
    localparam logic [3:0] K_BIN   = 4'd6;
    localparam logic [3:0] K_EXT   = 4'd7;
    localparam logic [3:0] K_ARRAY = 4'd8;
    localparam logic [3:0] K_MAP   = 4'd9;
    localparam logic [3:0] K_BYTE  = 4'd10;

    // error codes
    localparam logic [2:0] E_NONE  = 3'd0;
    localparam logic [2:0] E_TRUNC = 3'd1;
    localparam logic [2:0] E_RSVD  = 3'd2;
    localparam logic [2:0] E_KEY   = 3'd3;
    localparam logic [2:0] E_DEPTH = 3'd4;

    // tag bytes
    localparam logic [7:0] T_NIL      = 8'hc0;
    localparam logic [7:0] T_RSVD     = 8'hc1;
    localparam logic [7:0] T_FALSE    = 8'hc2;
    localparam logic [7:0] T_TRUE     = 8'hc3;
    localparam logic [7:0] T_BIN8     = 8'hc4;
    localparam logic [7:0] T_BIN16    = 8'hc5;
    localparam logic [7:0] T_BIN32    = 8'hc6;
    localparam logic [7:0] T_EXT8     = 8'hc7;
    localparam logic [7:0] T_EXT16    = 8'hc8;
    localparam logic [7:0] T_EXT32    = 8'hc9;
    localparam logic [7:0] T_FLOAT32  = 8'hca;
    localparam logic [7:0] T_FLOAT64  = 8'hcb;
    localparam logic [7:0] T_UINT8    = 8'hcc;
    localparam logic [7:0] T_UINT16   = 8'hcd;
    localparam logic [7:0] T_UINT32   = 8'hce;
    localparam logic [7:0] T_UINT64   = 8'hcf;
    localparam logic [7:0] T_INT8     = 8'hd0;
    localparam logic [7:0] T_INT16    = 8'hd1;
    localparam logic [7:0] T_INT32    = 8'hd2;
    localparam logic [7:0] T_INT64    = 8'hd3;
    localparam logic [7:0] T_FIXEXT1  = 8'hd4;
    localparam logic [7:0] T_FIXEXT2  = 8'hd5;
    localparam logic [7:0] T_FIXEXT4  = 8'hd6;
    localparam logic [7:0] T_FIXEXT8  = 8'hd7;
    localparam logic [7:0] T_FIXEXT16 = 8'hd8;
    localparam logic [7:0] T_STR8     = 8'hd9;
    localparam logic [7:0] T_STR16    = 8'hda;
    localparam logic [7:0] T_STR32    = 8'hdb;
    localparam logic [7:0] T_ARRAY16  = 8'hdc;
    localparam logic [7:0] T_ARRAY32  = 8'hdd;
    localparam logic [7:0] T_MAP16    = 8'hde;
    localparam logic [7:0] T_MAP32    = 8'hdf;

    // one nesting level as stored in the stack memory
    typedef struct packed {
        logic        is_map;
        logic [32:0] remaining;
    } level_t;

    // bytes that follow a multi-byte tag before its token is complete
    function automatic logic [3:0] hdr_len(input logic [7:0] t);
        logic [3:0] n;
        case (t)
            T_UINT8, T_INT8, T_STR8, T_BIN8:                          n = 4'd1;
            T_UINT16, T_INT16, T_STR16, T_BIN16, T_ARRAY16, T_MAP16,
            T_EXT8:                                                   n = 4'd2;
            T_EXT16:                                                  n = 4'd3;
            T_UINT32, T_INT32, T_FLOAT32, T_STR32, T_BIN32, T_ARRAY32,
            T_MAP32:                                                  n = 4'd4;
            T_EXT32:                                                  n = 4'd5;
            T_UINT64, T_INT64, T_FLOAT64:                             n = 4'd8;
            T_FIXEXT1, T_FIXEXT2, T_FIXEXT4, T_FIXEXT8, T_FIXEXT16:   n = 4'd1;
            default:                                                  n = 4'd0;
        endcase
        return n;
    endfunction

    // exact float32 -> float64 bit conversion
    function automatic logic [63:0] widen_f32(input logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] m;
        logic [4:0]  k;
        logic [22:0] sh;
        logic [63:0] r;
        e = b[30:23];
        m = b[22:0];
        k = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (m[i]) begin
                k = 5'(i);
            end
        end
        sh = m << (5'd23 - k);
        if (e == 8'hff) begin
            if (m == '0) begin
                r = {b[31], 11'h7ff, 52'd0};
            end else begin
                r = {b[31], 11'h7ff, 1'b1, m[21:0], 29'd0};
            end
        end else if (e == 8'd0) begin
            if (m == '0) begin
                r = {b[31], 63'd0};
            end else begin
                r = {b[31], 11'(k) + 11'd874, sh, 29'd0};
            end
        end else begin
            r = {b[31], 11'(e) + 11'd896, m, 29'd0};
        end
        return r;
    endfunction

endpackage

// ----- hdl/msd_stack_ram.sv -----
// Nesting-level memory: one write port, one read port, registered read.
// Uses msd_pkg::level_t.
module msd_stack_ram #(
    parameter int DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  msd_pkg::level_t       wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output msd_pkg::level_t       rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    msd_pkg::level_t mem [DEPTH];
    msd_pkg::level_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/msgpack_stream_decoder.sv -----
// Top level of the MessagePack stream decoder: byte intake, header and
// payload sequencing, nesting stack control. Uses msd_pkg, msd_stack_ram.
//
//  channel | signals                                         | dir | item
//  --------+-------------------------------------------------+-----+-------------------
//  in      | in_valid/in_ready, in_byte, byte_valid,         | in  | one encoded byte
//          | end_of_buffer                                   |     | or end marker
//  out     | out_valid/out_ready, token_kind, value, length, | out | one decoded token
//          | depth, is_key, value_done, error_code           |     |
//
// An item is taken in C_RUN; its token is held in the token registers and
// moves to the output register from C_SEND, so no new item is taken until
// the token has moved on. When an element closes levels that are still held
// in the stack memory, each further level takes one memory read in C_POP.
// Reset needs no clearing pass: only entries written by a push are read.
// A token waiting in the output register does not block the next item; the
// block stalls only while a second token would have no place to go.
`include "assert_macros.svh"

module msgpack_stream_decoder #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        byte_valid,
    input  logic        end_of_buffer,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [63:0] value,
    output logic [31:0] length,
    output logic [4:0]  depth,
    output logic        is_key,
    output logic        value_done,
    output logic [2:0]  error_code
);

    localparam int TW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // decode phase
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // control sequencer
    localparam logic [1:0] C_RUN  = 2'd0;  // take an item
    localparam logic [1:0] C_POP  = 2'd1;  // closing levels from memory
    localparam logic [1:0] C_SEND = 2'd2;  // token ready for output register

    // decoded action of a tag or a completed header
    localparam logic [2:0] A_NONE   = 3'd0;
    localparam logic [2:0] A_SCALAR = 3'd1;
    localparam logic [2:0] A_BLOB   = 3'd2;
    localparam logic [2:0] A_CONT   = 3'd3;
    localparam logic [2:0] A_FAIL   = 3'd4;

    // decoder state
    logic [1:0]    phase_reg, phase_next;
    logic [7:0]    tag_reg, tag_next;
    logic [63:0]   acc_reg, acc_next;
    logic [3:0]    hleft_reg, hleft_next;
    logic [31:0]   pleft_reg, pleft_next;
    logic [TW-1:0] top_reg, top_next;
    logic [32:0]   crem_reg, crem_next;   // cached top level: remaining count
    logic          cmap_reg, cmap_next;   // cached top level: is a map
    logic          fin_reg, fin_next;
    logic [1:0]    ctl_reg, ctl_next;

    // token being built
    logic [3:0]  tok_kind_reg, tok_kind_next;
    logic [63:0] tok_value_reg, tok_value_next;
    logic [31:0] tok_length_reg, tok_length_next;
    logic [4:0]  tok_depth_reg, tok_depth_next;
    logic        tok_key_reg, tok_key_next;
    logic        tok_done_reg, tok_done_next;
    logic [2:0]  tok_err_reg, tok_err_next;
    logic        tok_emit_reg, tok_emit_next;
    logic        tok_end_reg, tok_end_next;

    // output register
    logic        out_valid_reg;
    logic [3:0]  out_kind_reg;
    logic [63:0] out_value_reg;
    logic [31:0] out_length_reg;
    logic [4:0]  out_depth_reg;
    logic        out_key_reg;
    logic        out_done_reg;
    logic [2:0]  out_err_reg;

    // stack memory port
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    msd_pkg::level_t ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    msd_pkg::level_t ram_rdata;

    logic send_go;

    msd_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready = (ctl_reg == C_RUN);
    assign send_go  = (ctl_reg == C_SEND) && (!out_valid_reg || out_ready);

    always_comb
    begin
        logic          want_key;
        logic          keyok;
        logic [63:0]   acc_sh;
        logic [3:0]    hl;
        logic [31:0]   pl;
        logic [2:0]    act;
        logic [3:0]    a_kind;
        logic [63:0]   a_val;
        logic [31:0]   a_len;
        logic          a_map;
        logic [2:0]    a_err;
        logic          elem;
        logic          push;
        logic          fail_now;
        logic [2:0]    fail_code;
        logic          finish;
        logic [32:0]   rem_dec;
        logic [32:0]   rd_dec;
        logic [TW-1:0] top_dec;
        logic [TW-1:0] top_dec2;

        phase_next  = phase_reg;
        tag_next    = tag_reg;
        acc_next    = acc_reg;
        hleft_next  = hleft_reg;
        pleft_next  = pleft_reg;
        top_next    = top_reg;
        crem_next   = crem_reg;
        cmap_next   = cmap_reg;
        fin_next    = fin_reg;
        ctl_next    = ctl_reg;

        tok_kind_next   = tok_kind_reg;
        tok_value_next  = tok_value_reg;
        tok_length_next = tok_length_reg;
        tok_depth_next  = tok_depth_reg;
        tok_key_next    = tok_key_reg;
        tok_done_next   = tok_done_reg;
        tok_err_next    = tok_err_reg;
        tok_emit_next   = tok_emit_reg;
        tok_end_next    = tok_end_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        act       = A_NONE;
        a_kind    = msd_pkg::K_NIL;
        a_val     = '0;
        a_len     = '0;
        a_map     = 1'b0;
        a_err     = msd_pkg::E_NONE;
        elem      = 1'b0;
        push      = 1'b0;
        fail_now  = 1'b0;
        fail_code = msd_pkg::E_NONE;
        finish    = 1'b0;

        want_key = (top_reg != '0) && cmap_reg && !crem_reg[0];
        keyok    = (in_byte[7:5] == 3'b101)
                || (in_byte >= msd_pkg::T_BIN8 && in_byte <= msd_pkg::T_EXT32)
                || (in_byte >= msd_pkg::T_FIXEXT1 && in_byte <= msd_pkg::T_STR32);
        acc_sh   = {acc_reg[55:0], in_byte};
        hl       = hleft_reg - {3'd0, hleft_reg != 4'd0};
        pl       = pleft_reg - {31'd0, pleft_reg != 32'd0};
        rem_dec  = crem_reg - 33'd1;
        rd_dec   = ram_rdata.remaining - 33'd1;
        top_dec  = top_reg - TW'(1);
        top_dec2 = top_reg - TW'(2);

        case (ctl_reg)
            C_RUN:
            begin
                tok_kind_next   = msd_pkg::K_NIL;
                tok_value_next  = '0;
                tok_length_next = '0;
                tok_depth_next  = 5'(top_reg);
                tok_key_next    = 1'b0;
                tok_done_next   = 1'b0;
                tok_err_next    = msd_pkg::E_NONE;
                tok_emit_next   = 1'b0;
                tok_end_next    = end_of_buffer;
                if (in_valid)
                begin
                    if (byte_valid && !fin_reg)
                    begin
                        case (phase_reg)
                            PH_HEADER:
                            begin
                                acc_next   = acc_sh;
                                hleft_next = hl;
                                if (hl == 4'd0)
                                begin
                                    phase_next = PH_IDLE;
                                    case (tag_reg)
                                        msd_pkg::T_UINT8, msd_pkg::T_UINT16,
                                        msd_pkg::T_UINT32, msd_pkg::T_INT64:
                                        begin
                                            act = A_SCALAR; a_kind = msd_pkg::K_INT;
                                            a_val = acc_sh;
                                        end
                                        msd_pkg::T_UINT64:
                                        begin
                                            act = A_SCALAR; a_kind = msd_pkg::K_INT;
                                            a_val = acc_sh[63] ? 64'h7fff_ffff_ffff_ffff
                                                               : acc_sh;
                                        end
                                        msd_pkg::T_INT8:
                                        begin
                                            act = A_SCALAR; a_kind = msd_pkg::K_INT;
                                            a_val = {{56{acc_sh[7]}}, acc_sh[7:0]};
                                        end
                                        msd_pkg::T_INT16:
                                        begin
                                            act = A_SCALAR; a_kind = msd_pkg::K_INT;
                                            a_val = {{48{acc_sh[15]}}, acc_sh[15:0]};
                                        end
                                        msd_pkg::T_INT32:
                                        begin
                                            act = A_SCALAR; a_kind = msd_pkg::K_INT;
                                            a_val = {{32{acc_sh[31]}}, acc_sh[31:0]};
                                        end
                                        msd_pkg::T_FLOAT64:
                                        begin
                                            act = A_SCALAR; a_kind = msd_pkg::K_F64;
                                            a_val = acc_sh;
                                        end
                                        msd_pkg::T_FLOAT32:
                                        begin
                                            act = A_SCALAR; a_kind = msd_pkg::K_F64;
                                            a_val = msd_pkg::widen_f32(acc_sh[31:0]);
                                        end
                                        msd_pkg::T_STR8, msd_pkg::T_STR16,
                                        msd_pkg::T_STR32:
                                        begin
                                            act = A_BLOB; a_kind = msd_pkg::K_STR;
                                            a_len = acc_sh[31:0];
                                        end
                                        msd_pkg::T_BIN8, msd_pkg::T_BIN16,
                                        msd_pkg::T_BIN32:
                                        begin
                                            act = A_BLOB; a_kind = msd_pkg::K_BIN;
                                            a_len = acc_sh[31:0];
                                        end
                                        msd_pkg::T_EXT8, msd_pkg::T_EXT16,
                                        msd_pkg::T_EXT32:
                                        begin
                                            // length bytes first, type byte last
                                            act = A_BLOB; a_kind = msd_pkg::K_EXT;
                                            a_val = {56'd0, acc_sh[7:0]};
                                            a_len = acc_sh[39:8];
                                        end
                                        msd_pkg::T_FIXEXT1, msd_pkg::T_FIXEXT2,
                                        msd_pkg::T_FIXEXT4, msd_pkg::T_FIXEXT8,
                                        msd_pkg::T_FIXEXT16:
                                        begin
                                            act = A_BLOB; a_kind = msd_pkg::K_EXT;
                                            a_val = {56'd0, acc_sh[7:0]};
                                            a_len = 32'd1 << 3'(tag_reg[2:0] - 3'd4);
                                        end
                                        msd_pkg::T_ARRAY16, msd_pkg::T_ARRAY32:
                                        begin
                                            act = A_CONT; a_len = acc_sh[31:0];
                                        end
                                        msd_pkg::T_MAP16, msd_pkg::T_MAP32:
                                        begin
                                            act = A_CONT; a_map = 1'b1;
                                            a_len = acc_sh[31:0];
                                        end
                                        default:
                                        begin
                                            act = A_FAIL; a_err = msd_pkg::E_RSVD;
                                        end
                                    endcase
                                end
                            end
                            PH_PAYLOAD:
                            begin
                                tok_emit_next  = 1'b1;
                                tok_kind_next  = msd_pkg::K_BYTE;
                                tok_value_next = {56'd0, in_byte};
                                pleft_next     = pl;
                                if (pl == 32'd0)
                                begin
                                    phase_next = PH_IDLE;
                                    elem       = 1'b1;
                                end
                            end
                            default:
                            begin
                                if (in_byte == msd_pkg::T_RSVD)
                                begin
                                    act = A_FAIL; a_err = msd_pkg::E_RSVD;
                                end
                                else if (want_key && !keyok)
                                begin
                                    act = A_FAIL; a_err = msd_pkg::E_KEY;
                                end
                                else if (!in_byte[7])
                                begin
                                    act = A_SCALAR; a_kind = msd_pkg::K_INT;
                                    a_val = {56'd0, in_byte};
                                end
                                else if (in_byte[7:5] == 3'b111)
                                begin
                                    act = A_SCALAR; a_kind = msd_pkg::K_INT;
                                    a_val = {{56{1'b1}}, in_byte};
                                end
                                else if (in_byte == msd_pkg::T_NIL)
                                begin
                                    act = A_SCALAR; a_kind = msd_pkg::K_NIL;
                                end
                                else if (in_byte == msd_pkg::T_FALSE)
                                begin
                                    act = A_SCALAR; a_kind = msd_pkg::K_FALSE;
                                end
                                else if (in_byte == msd_pkg::T_TRUE)
                                begin
                                    act = A_SCALAR; a_kind = msd_pkg::K_TRUE;
                                end
                                else if (in_byte[7:5] == 3'b101)
                                begin
                                    act = A_BLOB; a_kind = msd_pkg::K_STR;
                                    a_len = {27'd0, in_byte[4:0]};
                                end
                                else if (in_byte[7:4] == 4'b1001)
                                begin
                                    act = A_CONT; a_len = {28'd0, in_byte[3:0]};
                                end
                                else if (in_byte[7:4] == 4'b1000)
                                begin
                                    act = A_CONT; a_map = 1'b1;
                                    a_len = {28'd0, in_byte[3:0]};
                                end
                                else
                                begin
                                    tag_next   = in_byte;
                                    acc_next   = '0;
                                    hleft_next = msd_pkg::hdr_len(in_byte);
                                    phase_next = PH_HEADER;
                                end
                            end
                        endcase
                    end

                    case (act)
                        A_SCALAR:
                        begin
                            tok_emit_next  = 1'b1;
                            tok_kind_next  = a_kind;
                            tok_value_next = a_val;
                            tok_key_next   = want_key;
                            phase_next     = PH_IDLE;
                            elem           = 1'b1;
                        end
                        A_BLOB:
                        begin
                            tok_emit_next   = 1'b1;
                            tok_kind_next   = a_kind;
                            tok_value_next  = a_val;
                            tok_length_next = a_len;
                            tok_key_next    = want_key;
                            if (a_len == 32'd0)
                            begin
                                phase_next = PH_IDLE;
                                elem       = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                                pleft_next = a_len;
                            end
                        end
                        A_CONT:
                        begin
                            phase_next = PH_IDLE;
                            if (a_len != 32'd0 && top_reg >= TW'(STACK_DEPTH))
                            begin
                                fail_now  = 1'b1;
                                fail_code = msd_pkg::E_DEPTH;
                            end
                            else
                            begin
                                tok_emit_next   = 1'b1;
                                tok_kind_next   = a_map ? msd_pkg::K_MAP : msd_pkg::K_ARRAY;
                                tok_length_next = a_len;
                                tok_key_next    = want_key;
                                if (a_len == 32'd0)
                                begin
                                    elem = 1'b1;
                                end
                                else
                                begin
                                    push = 1'b1;
                                end
                            end
                        end
                        A_FAIL:
                        begin
                            fail_now  = 1'b1;
                            fail_code = a_err;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (fail_now)
                    begin
                        tok_emit_next   = 1'b1;
                        tok_kind_next   = msd_pkg::K_NIL;
                        tok_value_next  = '0;
                        tok_length_next = '0;
                        tok_depth_next  = '0;
                        tok_key_next    = 1'b0;
                        tok_err_next    = fail_code;
                        fin_next        = 1'b1;
                        phase_next      = PH_IDLE;
                    end

                    // new level goes to the cache; old top spills to memory
                    if (push)
                    begin
                        if (top_reg != '0)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = top_dec[AW-1:0];
                            ram_wdata = '{is_map: cmap_reg, remaining: crem_reg};
                        end
                        crem_next = a_map ? {a_len, 1'b0} : {1'b0, a_len};
                        cmap_next = a_map;
                        top_next  = top_reg + TW'(1);
                    end

                    // first step of closing levels runs on the cached top
                    if (elem && top_reg == '0)
                    begin
                        fin_next      = 1'b1;
                        tok_done_next = 1'b1;
                        finish        = 1'b1;
                    end
                    else if (elem && rem_dec != '0)
                    begin
                        crem_next = rem_dec;
                        finish    = 1'b1;
                    end
                    else if (elem)
                    begin
                        top_next = top_dec;
                        if (top_dec == '0)
                        begin
                            fin_next      = 1'b1;
                            tok_done_next = 1'b1;
                            finish        = 1'b1;
                        end
                        else
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = top_dec2[AW-1:0];
                            ctl_next  = C_POP;
                        end
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            C_POP:
            begin
                if (rd_dec != '0)
                begin
                    crem_next = rd_dec;
                    cmap_next = ram_rdata.is_map;
                    finish    = 1'b1;
                end
                else
                begin
                    top_next = top_dec;
                    if (top_dec == '0)
                    begin
                        fin_next      = 1'b1;
                        tok_done_next = 1'b1;
                        finish        = 1'b1;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = top_dec2[AW-1:0];
                    end
                end
            end
            C_SEND:
            begin
                if (send_go)
                begin
                    ctl_next = C_RUN;
                end
            end
            default:
            begin
                ctl_next = C_RUN;
            end
        endcase

        // close out the item: truncation check, rearm at end of buffer
        if (finish)
        begin
            if (tok_end_next && !fin_next)
            begin
                if (!tok_emit_next)
                begin
                    tok_kind_next   = msd_pkg::K_NIL;
                    tok_value_next  = '0;
                    tok_length_next = '0;
                    tok_depth_next  = '0;
                    tok_key_next    = 1'b0;
                    tok_done_next   = 1'b0;
                end
                tok_err_next  = msd_pkg::E_TRUNC;
                tok_emit_next = 1'b1;
            end
            if (tok_end_next)
            begin
                phase_next = PH_IDLE;
                tag_next   = '0;
                acc_next   = '0;
                hleft_next = '0;
                pleft_next = '0;
                top_next   = '0;
                crem_next  = '0;
                cmap_next  = 1'b0;
                fin_next   = 1'b0;
            end
            ctl_next = tok_emit_next ? C_SEND : C_RUN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tag_reg       <= '0;
            acc_reg       <= '0;
            hleft_reg     <= '0;
            pleft_reg     <= '0;
            top_reg       <= '0;
            crem_reg      <= '0;
            cmap_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            ctl_reg       <= C_RUN;
            tok_emit_reg  <= 1'b0;
            tok_end_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            tag_reg      <= tag_next;
            acc_reg      <= acc_next;
            hleft_reg    <= hleft_next;
            pleft_reg    <= pleft_next;
            top_reg      <= top_next;
            crem_reg     <= crem_next;
            cmap_reg     <= cmap_next;
            fin_reg      <= fin_next;
            ctl_reg      <= ctl_next;
            tok_emit_reg <= tok_emit_next;
            tok_end_reg  <= tok_end_next;
            if (send_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // token payload, no reset
    always_ff @(posedge clk)
    begin
        tok_kind_reg   <= tok_kind_next;
        tok_value_reg  <= tok_value_next;
        tok_length_reg <= tok_length_next;
        tok_depth_reg  <= tok_depth_next;
        tok_key_reg    <= tok_key_next;
        tok_done_reg   <= tok_done_next;
        tok_err_reg    <= tok_err_next;
        if (send_go)
        begin
            out_kind_reg   <= tok_kind_reg;
            out_value_reg  <= tok_value_reg;
            out_length_reg <= tok_length_reg;
            out_depth_reg  <= tok_depth_reg;
            out_key_reg    <= tok_key_reg;
            out_done_reg   <= tok_done_reg;
            out_err_reg    <= tok_err_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign token_kind = out_kind_reg;
    assign value      = out_value_reg;
    assign length     = out_length_reg;
    assign depth      = out_depth_reg;
    assign is_key     = out_key_reg;
    assign value_done = out_done_reg;
    assign error_code = out_err_reg;

    `MSD_ASSERT(a_top_bound, top_reg <= TW'(STACK_DEPTH), "stack top beyond depth")
    `MSD_ASSERT_IMPL(a_pop_nonroot, ctl_reg == C_POP, top_reg != '0, "pop with empty stack")
    `MSD_ASSERT_IMPL(a_done_clean, out_valid_reg && out_done_reg, out_err_reg == msd_pkg::E_NONE, "done token with error")
    `MSD_ASSERT_NEXT(a_end_rearm, in_valid && in_ready && end_of_buffer, top_reg == '0 || ctl_reg == C_POP, "no rearm after end")

endmodule

// ----- tb/msgpack_token_checker.sv -----
// Token checker for the MessagePack stream decoder: watches both channels,
// predicts tokens from accepted items and compares. Uses msd_pkg.
`timescale 1ns / 100ps

module msgpack_token_checker
    import msd_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        byte_valid,
    input  logic        end_of_buffer,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  token_kind,
    input  logic [63:0] value,
    input  logic [31:0] length,
    input  logic [4:0]  depth,
    input  logic        is_key,
    input  logic        value_done,
    input  logic [2:0]  error_code,
    output int          fail_count,
    output int          pending,
    output int          token_count
);

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] val;
        logic [31:0] len;
        logic [4:0]  dep;
        logic        key;
        logic        done;
        logic [2:0]  err;
    } token_t;

    typedef enum logic [1:0] {ST_TAG, ST_HDR, ST_PAY} phase_t;

    token_t      token_q[$];
    phase_t      ph;
    logic [7:0]  tag;
    logic [63:0] acc;
    int          hdr_left;
    logic [31:0] pay_left;
    logic [32:0] lvl_rem[STACK_DEPTH];
    logic        lvl_map[STACK_DEPTH];
    int          top;
    logic        fin;
    token_t      tk;
    logic        have;

    assign pending = token_q.size();

    function automatic logic [63:0] sx(input logic [63:0] v, input int bits);
        logic [63:0] m;
        m = (64'd1 << bits) - 64'd1;
        v = v & m;
        if (v[bits-1])
            v = v | ~m;
        return v;
    endfunction

    function automatic logic [63:0] f32_to_f64(input logic [31:0] b);
        logic [63:0] s;
        logic [7:0]  e;
        logic [22:0] m;
        int          k;
        s = {b[31], 63'd0};
        e = b[30:23];
        m = b[22:0];
        if (e == 8'hff)
            return (m == 0) ? (s | {1'b0, 11'h7ff, 52'd0})
                            : (s | {1'b0, 11'h7ff, 1'b1, m[21:0], 29'd0});
        if (e == 0)
        begin
            if (m == 0)
                return s;
            k = 22;
            while (!m[k])
                k--;
            return s | (64'(k + 874) << 52) | ((64'(m) << (52 - k)) & 64'hf_ffff_ffff_ffff);
        end
        return s | (64'(e + 896) << 52) | (64'(m) << 29);
    endfunction

    function automatic logic want_key();
        if (top == 0 || top > STACK_DEPTH)
            return 1'b0;
        return lvl_map[top-1] && !lvl_rem[top-1][0];
    endfunction

    task automatic clear_state();
        ph = ST_TAG; tag = 0; acc = 0; hdr_left = 0; pay_left = 0;
        top = 0; fin = 0;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            lvl_rem[i] = 0; lvl_map[i] = 0;
        end
    endtask

    task automatic emit(input logic [3:0] k, input logic [63:0] v, input logic [63:0] l,
                        input logic key);
        tk = '{k, v, l[31:0], 5'(top), key, 1'b0, E_NONE};
        have = 1;
    endtask

    task automatic raise(input logic [2:0] code);
        tk = '0;
        tk.err = code;
        have = 1;
        fin = 1;
        ph = ST_TAG;
    endtask

    task automatic close_element();
        forever
        begin
            if (top == 0 || top > STACK_DEPTH)
            begin
                fin = 1;
                tk.done = 1;
                return;
            end
            lvl_rem[top-1] = lvl_rem[top-1] - 1;
            if (lvl_rem[top-1] != 0)
                return;
            top--;
        end
    endtask

    task automatic scalar(input logic [3:0] k, input logic [63:0] v);
        emit(k, v, 0, want_key());
        ph = ST_TAG;
        close_element();
    endtask

    task automatic blob(input logic [3:0] k, input logic [63:0] v, input logic [63:0] l);
        emit(k, v, l, want_key());
        if (l[31:0] == 0)
        begin
            ph = ST_TAG;
            close_element();
        end
        else
        begin
            ph = ST_PAY;
            pay_left = l[31:0];
        end
    endtask

    task automatic container(input logic is_map, input logic [63:0] cnt);
        ph = ST_TAG;
        if (cnt != 0 && top >= STACK_DEPTH)
        begin
            raise(E_DEPTH);
            return;
        end
        emit(is_map ? K_MAP : K_ARRAY, 0, cnt, want_key());
        if (cnt == 0)
            close_element();
        else
        begin
            lvl_rem[top] = is_map ? 33'(cnt) * 2 : 33'(cnt);
            lvl_map[top] = is_map;
            top++;
        end
    endtask

    task automatic take_tag(input logic [7:0] t);
        logic keyok;
        keyok = (t[7:5] == 3'b101) || (t >= T_BIN8 && t <= T_EXT32) ||
                (t >= T_FIXEXT1 && t <= T_STR32);
        if (t == T_RSVD) raise(E_RSVD);
        else if (want_key() && !keyok) raise(E_KEY);
        else if (t <= 8'h7f) scalar(K_INT, 64'(t));
        else if (t >= 8'he0) scalar(K_INT, sx(64'(t), 8));
        else if (t == T_NIL) scalar(K_NIL, 0);
        else if (t == T_FALSE) scalar(K_FALSE, 0);
        else if (t == T_TRUE) scalar(K_TRUE, 0);
        else if (t[7:5] == 3'b101) blob(K_STR, 0, 64'(t[4:0]));
        else if (t[7:4] == 4'h9) container(1'b0, 64'(t[3:0]));
        else if (t[7:4] == 4'h8) container(1'b1, 64'(t[3:0]));
        else
        begin
            tag = t;
            acc = 0;
            hdr_left = hdr_len(t);
            ph = ST_HDR;
        end
    endtask

    task automatic header_done();
        case (tag)
            T_UINT8, T_UINT16, T_UINT32: scalar(K_INT, acc);
            T_UINT64: scalar(K_INT, acc[63] ? 64'h7fff_ffff_ffff_ffff : acc);
            T_INT8: scalar(K_INT, sx(acc, 8));
            T_INT16: scalar(K_INT, sx(acc, 16));
            T_INT32: scalar(K_INT, sx(acc, 32));
            T_INT64: scalar(K_INT, acc);
            T_FLOAT64: scalar(K_F64, acc);
            T_FLOAT32: scalar(K_F64, f32_to_f64(acc[31:0]));
            T_STR8, T_STR16, T_STR32: blob(K_STR, 0, acc);
            T_BIN8, T_BIN16, T_BIN32: blob(K_BIN, 0, acc);
            T_EXT8, T_EXT16, T_EXT32: blob(K_EXT, 64'(acc[7:0]), acc >> 8);
            T_FIXEXT1, T_FIXEXT2, T_FIXEXT4, T_FIXEXT8, T_FIXEXT16:
                blob(K_EXT, 64'(acc[7:0]), 64'd1 << (tag - T_FIXEXT1));
            T_ARRAY16, T_ARRAY32: container(1'b0, acc);
            T_MAP16, T_MAP32: container(1'b1, acc);
            default: raise(E_RSVD);
        endcase
    endtask

    // One accepted item through the decoder model.
    task automatic decode_item(input logic [7:0] b, input logic bv, input logic eob);
        have = 0;
        tk = '0;
        if (bv && !fin)
        begin
            if (ph == ST_HDR)
            begin
                acc = (acc << 8) | 64'(b);
                if (hdr_left > 0)
                    hdr_left--;
                if (hdr_left == 0)
                begin
                    ph = ST_TAG;
                    header_done();
                end
            end
            else if (ph == ST_PAY)
            begin
                emit(K_BYTE, 64'(b), 0, 1'b0);
                if (pay_left > 0)
                    pay_left--;
                if (pay_left == 0)
                begin
                    ph = ST_TAG;
                    close_element();
                end
            end
            else
                take_tag(b);
        end
        if (eob)
        begin
            if (!fin)
            begin
                if (!have)
                    tk = '0;
                tk.err = E_TRUNC;
                have = 1;
            end
            clear_state();
        end
        if (have)
            token_q.push_back(tk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            token_q.delete();
            fail_count <= 0;
            token_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                token_count <= token_count + 1;
                if (token_q.size() == 0)
                begin
                    $display("%0t: unexpected token kind=%0d value=%h", $time, token_kind,
                             value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    token_t e;
                    token_t a;
                    e = token_q.pop_front();
                    a = '{token_kind, value, length, depth, is_key, value_done, error_code};
                    if (a !== e)
                    begin
                        $display("%0t: token mismatch", $time);
                        $display("  expected kind=%0d value=%h length=%h depth=%0d key=%b done=%b err=%0d",
                                 e.kind, e.val, e.len, e.dep, e.key, e.done, e.err);
                        $display("  actual   kind=%0d value=%h length=%h depth=%0d key=%b done=%b err=%0d",
                                 a.kind, a.val, a.len, a.dep, a.key, a.done, a.err);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                decode_item(in_byte, byte_valid, end_of_buffer);
        end
    end

endmodule

// ----- tb/msgpack_stream_decoder_tb.sv -----
// Top of the decoder testbench: clock, reset, byte stimulus, receiver stalls
// and verdict. Uses msd_pkg, msgpack_stream_decoder, msgpack_token_checker.
`timescale 1ns / 100ps

module msgpack_stream_decoder_tb;
    import msd_pkg::*;

    localparam int DEPTH_MAX = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        byte_valid;
    logic        end_of_buffer;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  token_kind;
    logic [63:0] value;
    logic [31:0] length;
    logic [4:0]  depth;
    logic        is_key;
    logic        value_done;
    logic [2:0]  error_code;
    int          fail_count;
    int          pending;
    int          token_count;
    int          cycles;
    int          items_sent;
    int          buffers_sent;
    logic        hold_off;

    // item under construction: byte, byte_valid, end flag
    typedef struct packed {
        logic [7:0] b;
        logic       bv;
        logic       eob;
    } item_t;

    item_t buf_q[$];

    msgpack_stream_decoder #(.STACK_DEPTH(DEPTH_MAX)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .in_byte(in_byte), .byte_valid(byte_valid), .end_of_buffer(end_of_buffer),
        .out_valid(out_valid), .out_ready(out_ready),
        .token_kind(token_kind), .value(value), .length(length), .depth(depth),
        .is_key(is_key), .value_done(value_done), .error_code(error_code)
    );

    msgpack_token_checker #(.STACK_DEPTH(DEPTH_MAX)) i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .in_byte(in_byte), .byte_valid(byte_valid), .end_of_buffer(end_of_buffer),
        .out_valid(out_valid), .out_ready(out_ready),
        .token_kind(token_kind), .value(value), .length(length), .depth(depth),
        .is_key(is_key), .value_done(value_done), .error_code(error_code),
        .fail_count(fail_count), .pending(pending), .token_count(token_count)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Watchdog: generous bound on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stall pattern, one long hold-off to back the block up,
    // and some stall-free stretches.
    initial
    begin
        int mode;
        out_ready = 1'b0;
        hold_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else
            begin
                mode = (cycles / 500) % 3;
                if (mode == 0)
                    out_ready <= 1'b1;
                else if (mode == 1)
                    out_ready <= ($urandom_range(0, 3) != 0);
                else
                    out_ready <= ($urandom_range(0, 1) != 0);
            end
        end
    end

    // Long hold-off, counted in cycles, while the sender keeps offering items.
    initial
    begin
        @(posedge rst_n);
        repeat (3000) @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    function automatic item_t mk(input logic [7:0] b, input logic eob = 1'b0);
        return '{b, 1'b1, eob};
    endfunction

    task automatic put_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            buf_q.push_back(mk(v[i*8 +: 8]));
    endtask

    // Append one random well-formed value, nesting at most lim levels deeper.
    task automatic gen_value(input int lim, input logic as_key);
        int sel;
        int n;
        logic [7:0] t;
        if (as_key)
        begin
            sel = $urandom_range(0, 3);
            n = $urandom_range(0, 3);
            case (sel)
                0: buf_q.push_back(mk(8'ha0 | 8'(n)));
                1: begin buf_q.push_back(mk(T_STR8)); put_be(n, 1); end
                2: begin buf_q.push_back(mk(T_BIN16)); put_be(n, 2); end
                default:
                begin
                    buf_q.push_back(mk(T_EXT32)); put_be(n, 4);
                    buf_q.push_back(mk(8'($urandom)));
                end
            endcase
            repeat (n) buf_q.push_back(mk(8'($urandom)));
            return;
        end
        sel = (lim > 0) ? $urandom_range(0, 13) : $urandom_range(0, 9);
        case (sel)
            0: buf_q.push_back(mk(8'($urandom_range(0, 127))));
            1: buf_q.push_back(mk(8'($urandom_range(224, 255))));
            2: buf_q.push_back(mk(8'($urandom_range(0, 2)) == 0 ? T_NIL :
                                 ($urandom_range(0, 1) ? T_TRUE : T_FALSE)));
            3:
            begin
                t = 8'($urandom_range(T_UINT8, T_INT64));
                buf_q.push_back(mk(t));
                put_be({$urandom, $urandom}, hdr_len(t));
            end
            4:
            begin
                buf_q.push_back(mk(T_FLOAT32));
                case ($urandom_range(0, 3))
                    0: put_be({32'd0, $urandom} & 64'h807f_ffff, 4);
                    1: put_be({32'd0, $urandom} | 64'h7f80_0000, 4);
                    default: put_be({32'd0, $urandom}, 4);
                endcase
            end
            5: begin buf_q.push_back(mk(T_FLOAT64)); put_be({$urandom, $urandom}, 8); end
            6:
            begin
                t = 8'($urandom_range(T_FIXEXT1, T_FIXEXT8));
                buf_q.push_back(mk(t));
                buf_q.push_back(mk(8'($urandom)));
                repeat (1 << (t - T_FIXEXT1)) buf_q.push_back(mk(8'($urandom)));
            end
            7, 8, 9: gen_value(0, 1'b1);
            10, 11:
            begin
                n = $urandom_range(0, 3);
                if ($urandom_range(0, 1))
                    buf_q.push_back(mk(8'h90 | 8'(n)));
                else
                begin
                    buf_q.push_back(mk(T_ARRAY32));
                    put_be(n, 4);
                end
                repeat (n) gen_value(lim - 1, 1'b0);
            end
            default:
            begin
                n = $urandom_range(0, 2);
                if ($urandom_range(0, 1))
                    buf_q.push_back(mk(8'h80 | 8'(n)));
                else
                begin
                    buf_q.push_back(mk(T_MAP16));
                    put_be(n, 2);
                end
                repeat (n)
                begin
                    gen_value(0, 1'b1);
                    gen_value(lim - 1, 1'b0);
                end
            end
        endcase
    endtask

    // Close the buffer: mark the last byte or add a bare end marker.
    task automatic end_buffer();
        if (buf_q.size() == 0 || $urandom_range(0, 2) == 0)
            buf_q.push_back('{8'($urandom), 1'b0, 1'b1});
        else
            buf_q[$].eob = 1'b1;
    endtask

    // Drive everything in buf_q, with bursts and random gaps.
    task automatic send_all();
        item_t it;
        int burst;
        burst = 0;
        while (buf_q.size() != 0)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(0, 2) != 0)
                    repeat ($urandom_range(1, 6)) @(negedge clk);
                burst = $urandom_range(1, 20);
            end
            it = buf_q.pop_front();
            in_byte <= it.b;
            byte_valid <= it.bv;
            end_of_buffer <= it.eob;
            in_valid <= 1'b1;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            items_sent++;
            if (it.eob)
                buffers_sent++;
            burst--;
            @(negedge clk);
            if (burst == 0 || buf_q.size() == 0)
                in_valid <= 1'b0;
        end
    endtask

    initial
    begin
        int kind;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'd0;
        byte_valid = 1'b0;
        end_of_buffer = 1'b0;
        cycles = 0;
        items_sent = 0;
        buffers_sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes and each special case, one short buffer each.
        buf_q.push_back('{8'h00, 1'b0, 1'b1});                 // empty buffer
        buf_q.push_back(mk(T_UINT64));                         // clamped uint64
        put_be(64'hffff_ffff_ffff_ffff, 8); buf_q[$].eob = 1;
        buf_q.push_back(mk(T_RSVD, 1'b1));                     // reserved tag
        buf_q.push_back(mk(8'h81)); buf_q.push_back(mk(8'h01)); // bad key
        buf_q.push_back(mk(8'h00, 1'b1));
        repeat (DEPTH_MAX + 1) buf_q.push_back(mk(8'h91));     // too deep
        buf_q[$].eob = 1;
        buf_q.push_back(mk(T_EXT16)); put_be(24'h000002_7f, 3); // ext16 with data
        buf_q.push_back(mk(8'hff)); buf_q.push_back(mk(8'h00));
        buf_q.push_back(mk(8'h55)); buf_q.push_back(mk(8'h66, 1'b1)); // trailing
        buf_q.push_back(mk(8'h90)); buf_q.push_back(mk(8'h80, 1'b1)); // empties
        buf_q.push_back(mk(8'h92)); buf_q.push_back(mk(8'h91));
        buf_q.push_back(mk(8'h91)); buf_q.push_back(mk(8'hc3));   // multi-level close
        buf_q.push_back(mk(8'h01, 1'b1));
        buf_q.push_back(mk(T_STR8)); buf_q.push_back(mk(8'h03));
        buf_q.push_back(mk(8'h41, 1'b1));                     // truncated payload
        buf_q.push_back(mk(8'ha0)); buf_q.push_back('{8'h00, 1'b0, 1'b0}); // bare item
        buf_q.push_back('{8'h00, 1'b0, 1'b1});
        send_all();

        // Random buffers: mostly well-formed, some broken or noisy.
        while (items_sent < 1250)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                gen_value(4, 1'b0);
            else if (kind == 7)
                repeat ($urandom_range(1, 8)) buf_q.push_back(mk(8'($urandom)));
            else
            begin
                gen_value(4, 1'b0);
                if (buf_q.size() > 1)
                    void'(buf_q.pop_back());
            end
            if ($urandom_range(0, 4) == 0)
                buf_q.push_back(mk(8'($urandom)));
            end_buffer();
            send_all();
        end

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("sent %0d items in %0d buffers, checked %0d tokens",
                 items_sent, buffers_sent, token_count);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/msd_pkg.sv
hdl/msd_stack_ram.sv
hdl/msgpack_stream_decoder.sv
tb/msgpack_token_checker.sv
tb/msgpack_stream_decoder_tb.sv
